// File: rtl/core/tsgi_pkg.sv
// Shared types and constants for the two-switch gate interlock.
package tsgi_pkg;

  localparam int DEB_W   = 10;
  localparam int DELAY_W = 8;
  localparam int DTAP_W  = 14;
  localparam int ANGLE_W = 8;
  localparam int ERR_W   = 2;
  localparam int STAT_W  = 3;
  localparam int SEC_W   = 8;
  localparam int TMR_W   = 16;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 14;

  localparam logic [CIDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_GATE_DELAY = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_DOUBLE_TAP = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_OPEN_A     = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_CLOSED_A   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_OPEN_B     = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_CLOSED_B   = 3'd6;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RST   = 10'd50;
  localparam logic [DELAY_W-1:0] GATE_DELAY_RST = 8'd10;
  localparam logic [DTAP_W-1:0]  DOUBLE_TAP_RST = 14'd1000;
  localparam logic [ANGLE_W-1:0] OPEN_ANGLE_RST = 8'd90;
  localparam logic [ANGLE_W-1:0] CLOSED_ANGLE_RST = 8'd0;

  localparam logic [STAT_W-1:0] STAT_CLOSED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OPEN    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_CLOSING = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FAULT1  = 3'd3;

  localparam logic [TMR_W-1:0] TMR_MAX     = 16'hFFFF;
  localparam logic [SEC_W-1:0] ELAPSED_MAX = 8'hFF;

  typedef struct packed {
    logic [DEB_W-1:0]   debounce_ms;
    logic [DELAY_W-1:0] gate_delay_sec;
    logic [DTAP_W-1:0]  double_tap_ms;
    logic [ANGLE_W-1:0] open_angle_a;
    logic [ANGLE_W-1:0] closed_angle_a;
    logic [ANGLE_W-1:0] open_angle_b;
    logic [ANGLE_W-1:0] closed_angle_b;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] servo_a_angle;
    logic [ANGLE_W-1:0] servo_b_angle;
    logic               relay_on;
    logic [STAT_W-1:0]  gate_status;
    logic               opening_event;
    logic [SEC_W-1:0]   remaining_sec;
  } result_t;

endpackage

// File: rtl/core/tsgi_ifs.sv
// Channel interfaces: switch input, result and configuration write.
interface tsgi_in_if;
  logic                        valid;
  logic                        ready;
  logic                        a_level;
  logic                        b_level;
  logic [tsgi_pkg::ERR_W-1:0]  error_code;

  modport source (output valid, a_level, b_level, error_code, input ready);
  modport sink (input valid, a_level, b_level, error_code, output ready);
endinterface

interface tsgi_out_if;
  logic                          valid;
  logic                          ready;
  logic [tsgi_pkg::ANGLE_W-1:0]  servo_a_angle;
  logic [tsgi_pkg::ANGLE_W-1:0]  servo_b_angle;
  logic                          relay_on;
  logic [tsgi_pkg::STAT_W-1:0]   gate_status;
  logic                          opening_event;
  logic [tsgi_pkg::SEC_W-1:0]    remaining_sec;

  modport source (output valid, servo_a_angle, servo_b_angle, relay_on, gate_status,
                  opening_event, remaining_sec, input ready);
  modport sink (input valid, servo_a_angle, servo_b_angle, relay_on, gate_status,
                opening_event, remaining_sec, output ready);
endinterface

interface tsgi_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tsgi_pkg::CIDX_W-1:0]  index;
  logic [tsgi_pkg::CDAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/two_switch_gate_interlock_unit.sv
// Top level of the two-switch gate interlock: input register, control core, result register.
//
// Usage: send one item on in_ch per 1 ms tick, carrying the raw active-low levels of
// switch A and switch B and an external fault code. Each item yields exactly one
// result item on out_ch: both servo angles, relay enable, gate status, an opening
// flag and the seconds left on the servo B close countdown.
// Registers (debounce time, close delay, double-release window, four servo angles)
// are written on cfg_ch by index; cfg_ch is always ready. Write them only while
// no item is in flight; angle changes show on the next result.
// Each item passes through the input register, then the result register. Throughput:
// one item per cycle while out_ch does not stall, set by the combinational state update
// between the two registers.
// Reset (rst_n low, synchronous) loads the register defaults, treats both switches as
// released with both servos closed and no countdown, and empties both registers.
// When out_ch stalls, the result register holds its item and the input register
// takes one more item; in_ch.ready then drops until out_ch accepts.
module two_switch_gate_interlock_unit #(
  parameter int MAX_COUNTDOWN_SEC = 180,
  parameter int TICKS_PER_SEC     = 1000
) (
  input logic         clk,
  input logic         rst_n,
  tsgi_in_if.sink     in_ch,
  tsgi_out_if.source  out_ch,
  tsgi_cfg_if.sink    cfg_ch
);
  import tsgi_pkg::*;

  logic             s1_valid_r;
  logic             s1_a_r, s1_b_r;
  logic [ERR_W-1:0] s1_err_r;
  logic             out_valid_r;
  result_t          out_r;
  result_t          res;
  cfg_t             cfg;
  logic             advance;
  logic             step;

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  tsgi_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  tsgi_ctrl #(
    .MAX_COUNTDOWN_SEC (MAX_COUNTDOWN_SEC),
    .TICKS_PER_SEC     (TICKS_PER_SEC)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .a_level    (s1_a_r),
    .b_level    (s1_b_r),
    .error_code (s1_err_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_a_r   <= in_ch.a_level;
      s1_b_r   <= in_ch.b_level;
      s1_err_r <= in_ch.error_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.servo_a_angle = out_r.servo_a_angle;
  assign out_ch.servo_b_angle = out_r.servo_b_angle;
  assign out_ch.relay_on      = out_r.relay_on;
  assign out_ch.gate_status   = out_r.gate_status;
  assign out_ch.opening_event = out_r.opening_event;
  assign out_ch.remaining_sec = out_r.remaining_sec;

  a_open_relay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.opening_event |-> out_r.relay_on)
    else $error("opening event without relay");

  a_rem_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.remaining_sec <= SEC_W'(MAX_COUNTDOWN_SEC))
    else $error("remaining seconds above cap");

  a_rem_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.remaining_sec != '0 |->
      out_r.gate_status == STAT_CLOSING || out_r.gate_status >= STAT_FAULT1)
    else $error("countdown shown without closing status");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable({s1_a_r, s1_b_r, s1_err_r}))
    else $error("input register lost a stalled item");

endmodule

// File: rtl/core/tsgi_cfg_regs.sv
// Configuration register file written through the configuration channel.
module tsgi_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  tsgi_cfg_if.sink        cfg_ch,
  output tsgi_pkg::cfg_t  cfg
);
  import tsgi_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms    <= DEBOUNCE_RST;
      cfg_r.gate_delay_sec <= GATE_DELAY_RST;
      cfg_r.double_tap_ms  <= DOUBLE_TAP_RST;
      cfg_r.open_angle_a   <= OPEN_ANGLE_RST;
      cfg_r.closed_angle_a <= CLOSED_ANGLE_RST;
      cfg_r.open_angle_b   <= OPEN_ANGLE_RST;
      cfg_r.closed_angle_b <= CLOSED_ANGLE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_DEBOUNCE:   cfg_r.debounce_ms    <= cfg_ch.data[DEB_W-1:0];
        CFG_GATE_DELAY: cfg_r.gate_delay_sec <= cfg_ch.data[DELAY_W-1:0];
        CFG_DOUBLE_TAP: cfg_r.double_tap_ms  <= cfg_ch.data[DTAP_W-1:0];
        CFG_OPEN_A:     cfg_r.open_angle_a   <= cfg_ch.data[ANGLE_W-1:0];
        CFG_CLOSED_A:   cfg_r.closed_angle_a <= cfg_ch.data[ANGLE_W-1:0];
        CFG_OPEN_B:     cfg_r.open_angle_b   <= cfg_ch.data[ANGLE_W-1:0];
        CFG_CLOSED_B:   cfg_r.closed_angle_b <= cfg_ch.data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/tsgi_ctrl.sv
// Debounce, servo and countdown state with the per-tick next-state and result logic.
module tsgi_ctrl #(
  parameter int MAX_COUNTDOWN_SEC = 180,
  parameter int TICKS_PER_SEC     = 1000
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       a_level,
  input  logic                       b_level,
  input  logic [tsgi_pkg::ERR_W-1:0] error_code,
  input  tsgi_pkg::cfg_t             cfg,
  output tsgi_pkg::result_t          res
);
  import tsgi_pkg::*;

  localparam int SUB_W = $clog2(TICKS_PER_SEC + 1);
  localparam int SUM_W = SEC_W + 2;
  localparam logic [SUB_W-1:0] TICKS_C = SUB_W'(TICKS_PER_SEC);
  localparam logic [SUM_W-1:0] MAX_C   = SUM_W'(MAX_COUNTDOWN_SEC);

  logic             a_prev_r, a_prev_nxt, a_stable_r, a_stable_nxt;
  logic [TMR_W-1:0] a_quiet_r, a_quiet_nxt;
  logic             b_prev_r, b_prev_nxt, b_stable_r, b_stable_nxt;
  logic [TMR_W-1:0] b_quiet_r, b_quiet_nxt;
  logic             sa_open_r, sa_open_nxt, sb_open_r, sb_open_nxt;
  logic             run_r, run_nxt, resume_r, resume_nxt, seen_r, seen_nxt;
  logic [SEC_W-1:0] total_r, total_nxt, elapsed_r, elapsed_nxt, paused_r, paused_nxt;
  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic [TMR_W-1:0] since_r, since_nxt;
  logic             opened;
  logic             dbl;
  logic [SEC_W-1:0] left;

  function automatic logic [SEC_W-1:0] left_sec(input logic [SEC_W-1:0] tot,
                                                input logic [SEC_W-1:0] el);
    left_sec = (tot > el) ? tot - el : '0;
  endfunction

  function automatic logic [SEC_W-1:0] cap_total(input logic [SEC_W-1:0] base,
                                                 input logic [SEC_W-1:0] add);
    logic [SUM_W-1:0] sum;
    sum = {2'b00, base} + {2'b00, add};
    cap_total = (sum > MAX_C) ? MAX_C[SEC_W-1:0] : sum[SEC_W-1:0];
  endfunction

  always_comb begin
    a_prev_nxt   = a_prev_r;
    a_stable_nxt = a_stable_r;
    a_quiet_nxt  = a_quiet_r;
    b_prev_nxt   = b_prev_r;
    b_stable_nxt = b_stable_r;
    b_quiet_nxt  = b_quiet_r;
    sa_open_nxt  = sa_open_r;
    sb_open_nxt  = sb_open_r;
    run_nxt      = run_r;
    resume_nxt   = resume_r;
    seen_nxt     = seen_r;
    total_nxt    = total_r;
    elapsed_nxt  = elapsed_r;
    paused_nxt   = paused_r;
    sub_nxt      = sub_r;
    since_nxt    = since_r;
    opened       = 1'b0;
    dbl          = 1'b0;

    if (since_nxt != TMR_MAX) since_nxt = since_nxt + 16'd1;
    if (run_nxt) begin
      sub_nxt = sub_nxt + SUB_W'(1);
      if (sub_nxt >= TICKS_C) begin
        sub_nxt = '0;
        if (elapsed_nxt != ELAPSED_MAX) elapsed_nxt = elapsed_nxt + 8'd1;
      end
    end

    if (a_level != a_prev_r) a_quiet_nxt = '0;
    else if (a_quiet_nxt != TMR_MAX) a_quiet_nxt = a_quiet_nxt + 16'd1;
    if (a_quiet_nxt > {6'd0, cfg.debounce_ms} && a_level != a_stable_r) begin
      a_stable_nxt = a_level;
      if (!a_level) begin
        sa_open_nxt = 1'b1;
        opened      = 1'b1;
        sb_open_nxt = 1'b0;
        run_nxt     = 1'b0;
        resume_nxt  = 1'b0;
        paused_nxt  = '0;
      end else begin
        sa_open_nxt = 1'b0;
      end
    end
    a_prev_nxt = a_level;

    if (!a_stable_nxt) begin
      run_nxt      = 1'b0;
      resume_nxt   = 1'b0;
      paused_nxt   = '0;
      b_quiet_nxt  = '0;
      b_prev_nxt   = b_level;
      b_stable_nxt = b_level;
    end else begin
      if (b_level != b_prev_r) b_quiet_nxt = '0;
      else if (b_quiet_nxt != TMR_MAX) b_quiet_nxt = b_quiet_nxt + 16'd1;
      if (b_quiet_nxt > {6'd0, cfg.debounce_ms} && b_level != b_stable_r) begin
        b_stable_nxt = b_level;
        if (!b_level) begin
          if (run_nxt) begin
            paused_nxt = left_sec(total_nxt, elapsed_nxt);
            resume_nxt = 1'b1;
          end
          run_nxt     = 1'b0;
          sb_open_nxt = 1'b1;
          opened      = 1'b1;
        end else begin
          dbl       = seen_nxt && (since_nxt < {2'b00, cfg.double_tap_ms});
          seen_nxt  = 1'b1;
          since_nxt = '0;
          if (dbl) begin
            run_nxt     = 1'b0;
            resume_nxt  = 1'b0;
            paused_nxt  = '0;
            total_nxt   = '0;
            sb_open_nxt = 1'b0;
          end else begin
            if (resume_nxt) begin
              total_nxt  = cap_total(paused_nxt, cfg.gate_delay_sec);
              resume_nxt = 1'b0;
              paused_nxt = '0;
            end else if (run_nxt) begin
              total_nxt = cap_total(left_sec(total_nxt, elapsed_nxt), cfg.gate_delay_sec);
            end else begin
              total_nxt = cap_total('0, cfg.gate_delay_sec);
            end
            run_nxt     = 1'b1;
            sub_nxt     = '0;
            elapsed_nxt = '0;
          end
        end
      end
      b_prev_nxt = b_level;

      if (run_nxt && elapsed_nxt >= total_nxt) begin
        sb_open_nxt = 1'b0;
        run_nxt     = 1'b0;
        resume_nxt  = 1'b0;
        paused_nxt  = '0;
      end
    end

    left = left_sec(total_nxt, elapsed_nxt);

    res.servo_a_angle = sa_open_nxt ? cfg.open_angle_a : cfg.closed_angle_a;
    res.servo_b_angle = sb_open_nxt ? cfg.open_angle_b : cfg.closed_angle_b;
    res.relay_on      = sa_open_nxt || sb_open_nxt;
    if (error_code != '0)              res.gate_status = {1'b0, error_code} + STAT_CLOSING;
    else if (run_nxt)                  res.gate_status = STAT_CLOSING;
    else if (sa_open_nxt || sb_open_nxt) res.gate_status = STAT_OPEN;
    else                               res.gate_status = STAT_CLOSED;
    res.opening_event = opened;
    res.remaining_sec = run_nxt ? left : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_prev_r  <= 1'b1;
      a_stable_r <= 1'b1;
      a_quiet_r <= '0;
      b_prev_r  <= 1'b1;
      b_stable_r <= 1'b1;
      b_quiet_r <= '0;
      sa_open_r <= 1'b0;
      sb_open_r <= 1'b0;
      run_r     <= 1'b0;
      resume_r  <= 1'b0;
      seen_r    <= 1'b0;
      total_r   <= '0;
      elapsed_r <= '0;
      paused_r  <= '0;
      sub_r     <= '0;
      since_r   <= '0;
    end else if (step) begin
      a_prev_r  <= a_prev_nxt;
      a_stable_r <= a_stable_nxt;
      a_quiet_r <= a_quiet_nxt;
      b_prev_r  <= b_prev_nxt;
      b_stable_r <= b_stable_nxt;
      b_quiet_r <= b_quiet_nxt;
      sa_open_r <= sa_open_nxt;
      sb_open_r <= sb_open_nxt;
      run_r     <= run_nxt;
      resume_r  <= resume_nxt;
      seen_r    <= seen_nxt;
      total_r   <= total_nxt;
      elapsed_r <= elapsed_nxt;
      paused_r  <= paused_nxt;
      sub_r     <= sub_nxt;
      since_r   <= since_nxt;
    end
  end

endmodule

// File: tb/tsgi_interlock_monitor.sv
// Watches the interlock channels, predicts each result item and compares it field by field.
module tsgi_interlock_monitor #(
  parameter int MAX_COUNTDOWN_SEC = 180,
  parameter int TICKS_PER_SEC     = 1000
) (
  input  logic clk,
  input  logic rst_n,
  tsgi_in_if   in_ch,
  tsgi_out_if  out_ch,
  tsgi_cfg_if  cfg_ch,
  output int   fail_count,
  output int   expected_left
);
  import tsgi_pkg::*;

  cfg_t    regs;
  result_t predicted_cmds[$];
  int      mismatches = 0;
  int      backlog = 0;
  int      results_seen = 0;

  logic             a_prev, a_stab, b_prev, b_stab;
  logic [TMR_W-1:0] a_quiet, b_quiet, since_rel;
  logic             srv_a, srv_b, cd_run, resume_pend, rel_seen;
  logic [SEC_W-1:0] cd_total, cd_elapsed, paused_left;
  logic [9:0]       cd_sub;

  assign fail_count    = mismatches;
  assign expected_left = backlog;

  task automatic flag_mismatch(input string msg);
    if (mismatches < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int secs_left();
    return (cd_total > cd_elapsed) ? int'(cd_total) - int'(cd_elapsed) : 0;
  endfunction

  function automatic logic [TMR_W-1:0] quiet_next(input logic [TMR_W-1:0] q,
                                                  input logic lvl, input logic prev);
    if (lvl != prev) return '0;
    return (q == TMR_MAX) ? q : q + 1'b1;
  endfunction

  task automatic launch_countdown(input int total);
    cd_run     = 1'b1;
    cd_total   = SEC_W'((total > MAX_COUNTDOWN_SEC) ? MAX_COUNTDOWN_SEC : total);
    cd_sub     = '0;
    cd_elapsed = '0;
  endtask

  task automatic halt_countdown();
    cd_run      = 1'b0;
    resume_pend = 1'b0;
    paused_left = '0;
  endtask

  task automatic tick_interlock(input logic a, input logic b, input logic [ERR_W-1:0] err);
    logic    opened;
    logic    dbl;
    result_t r;
    opened = 1'b0;
    if (since_rel != TMR_MAX) since_rel++;
    if (cd_run) begin
      cd_sub++;
      if (cd_sub >= TICKS_PER_SEC) begin
        cd_sub = '0;
        if (cd_elapsed != ELAPSED_MAX) cd_elapsed++;
      end
    end

    a_quiet = quiet_next(a_quiet, a, a_prev);
    if (a_quiet > regs.debounce_ms && a != a_stab) begin
      a_stab = a;
      if (!a) begin
        srv_a  = 1'b1;
        opened = 1'b1;
        srv_b  = 1'b0;
        halt_countdown();
      end else begin
        srv_a = 1'b0;
      end
    end
    a_prev = a;

    if (!a_stab) begin
      halt_countdown();
      b_quiet = '0;
      b_prev  = b;
      b_stab  = b;
    end else begin
      b_quiet = quiet_next(b_quiet, b, b_prev);
      if (b_quiet > regs.debounce_ms && b != b_stab) begin
        b_stab = b;
        if (!b) begin
          if (cd_run) begin
            paused_left = SEC_W'(secs_left());
            resume_pend = 1'b1;
          end
          cd_run = 1'b0;
          srv_b  = 1'b1;
          opened = 1'b1;
        end else begin
          dbl       = rel_seen && (since_rel < regs.double_tap_ms);
          rel_seen  = 1'b1;
          since_rel = '0;
          if (dbl) begin
            halt_countdown();
            cd_total = '0;
            srv_b    = 1'b0;
          end else if (resume_pend) begin
            launch_countdown(int'(paused_left) + int'(regs.gate_delay_sec));
            resume_pend = 1'b0;
            paused_left = '0;
          end else if (cd_run) begin
            launch_countdown(secs_left() + int'(regs.gate_delay_sec));
          end else begin
            launch_countdown(int'(regs.gate_delay_sec));
          end
        end
      end
      b_prev = b;
      if (cd_run && cd_elapsed >= cd_total) begin
        srv_b = 1'b0;
        halt_countdown();
      end
    end

    r.servo_a_angle = srv_a ? regs.open_angle_a : regs.closed_angle_a;
    r.servo_b_angle = srv_b ? regs.open_angle_b : regs.closed_angle_b;
    r.relay_on      = srv_a || srv_b;
    if (err != 0)          r.gate_status = STAT_W'(STAT_FAULT1 + err - 1);
    else if (cd_run)       r.gate_status = STAT_CLOSING;
    else if (srv_a || srv_b) r.gate_status = STAT_OPEN;
    else                   r.gate_status = STAT_CLOSED;
    r.opening_event = opened;
    r.remaining_sec = cd_run ? SEC_W'(secs_left()) : '0;
    predicted_cmds.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      regs.debounce_ms    = DEBOUNCE_RST;
      regs.gate_delay_sec = GATE_DELAY_RST;
      regs.double_tap_ms  = DOUBLE_TAP_RST;
      regs.open_angle_a   = OPEN_ANGLE_RST;
      regs.closed_angle_a = CLOSED_ANGLE_RST;
      regs.open_angle_b   = OPEN_ANGLE_RST;
      regs.closed_angle_b = CLOSED_ANGLE_RST;
      a_prev = 1'b1; a_stab = 1'b1; a_quiet = '0;
      b_prev = 1'b1; b_stab = 1'b1; b_quiet = '0;
      srv_a = 1'b0; srv_b = 1'b0;
      cd_run = 1'b0; resume_pend = 1'b0; rel_seen = 1'b0;
      cd_total = '0; cd_sub = '0; cd_elapsed = '0;
      paused_left = '0; since_rel = '0;
      predicted_cmds.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_DEBOUNCE:   regs.debounce_ms    = cfg_ch.data[DEB_W-1:0];
          CFG_GATE_DELAY: regs.gate_delay_sec = cfg_ch.data[DELAY_W-1:0];
          CFG_DOUBLE_TAP: regs.double_tap_ms  = cfg_ch.data[DTAP_W-1:0];
          CFG_OPEN_A:     regs.open_angle_a   = cfg_ch.data[ANGLE_W-1:0];
          CFG_CLOSED_A:   regs.closed_angle_a = cfg_ch.data[ANGLE_W-1:0];
          CFG_OPEN_B:     regs.open_angle_b   = cfg_ch.data[ANGLE_W-1:0];
          CFG_CLOSED_B:   regs.closed_angle_b = cfg_ch.data[ANGLE_W-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.servo_a_angle, out_ch.servo_b_angle, out_ch.relay_on,
               out_ch.gate_status, out_ch.opening_event, out_ch.remaining_sec};
        if (predicted_cmds.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no item outstanding", results_seen));
        end else begin
          want = predicted_cmds.pop_front();
          if (got.servo_a_angle !== want.servo_a_angle)
            flag_mismatch($sformatf("result %0d servo_a_angle %0d, want %0d",
                                    results_seen, got.servo_a_angle, want.servo_a_angle));
          if (got.servo_b_angle !== want.servo_b_angle)
            flag_mismatch($sformatf("result %0d servo_b_angle %0d, want %0d",
                                    results_seen, got.servo_b_angle, want.servo_b_angle));
          if (got.relay_on !== want.relay_on)
            flag_mismatch($sformatf("result %0d relay_on %0d, want %0d",
                                    results_seen, got.relay_on, want.relay_on));
          if (got.gate_status !== want.gate_status)
            flag_mismatch($sformatf("result %0d gate_status %0d, want %0d",
                                    results_seen, got.gate_status, want.gate_status));
          if (got.opening_event !== want.opening_event)
            flag_mismatch($sformatf("result %0d opening_event %0d, want %0d",
                                    results_seen, got.opening_event, want.opening_event));
          if (got.remaining_sec !== want.remaining_sec)
            flag_mismatch($sformatf("result %0d remaining_sec %0d, want %0d",
                                    results_seen, got.remaining_sec, want.remaining_sec));
        end
        results_seen++;
      end

      if (in_ch.valid && in_ch.ready)
        tick_interlock(in_ch.a_level, in_ch.b_level, in_ch.error_code);
    end
    backlog <= predicted_cmds.size();
  end

endmodule

// File: tb/tb_two_switch_gate_interlock_unit.sv
// Stimulus, idling and verdict for the two-switch gate interlock testbench.
module tb_two_switch_gate_interlock_unit;
  import tsgi_pkg::*;

  localparam logic [CIDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT  = 60000;
  localparam int STALL_CYCLES = 200;
  // {a_level, b_level, error_code} per tick, first tick in the top nibble
  localparam logic [99:0] DIRECTED_TICKS = 100'hCDEF443088CC88DC88CC28800;

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   want_stall;
  bit   stall_done;
  int   hold_left;
  int   fail_count;
  int   expected_left;
  logic [3:0] code;

  tsgi_in_if  in_ch();
  tsgi_out_if out_ch();
  tsgi_cfg_if cfg_ch();

  two_switch_gate_interlock_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tsgi_interlock_monitor monitor_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_two_switch_gate_interlock_unit: done, errors");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    stall_done   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (want_stall && !stall_done) begin
        stall_done = 1'b1;
        hold_left  = STALL_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 20);
      end
    end
  end

  task automatic send_item(input logic a, input logic b, input logic [ERR_W-1:0] e);
    while (idle_on && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.a_level    <= a;
    in_ch.b_level    <= b;
    in_ch.error_code <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drive_segment(input int n, input int run_min, input int run_max,
                               input int a_pct);
    int left;
    int run;
    int k;
    logic a, b, ga, gb;
    logic [ERR_W-1:0] e;
    left = n;
    while (left > 0) begin
      a   = ($urandom_range(99) < a_pct) ? 1'b0 : 1'b1;
      b   = 1'($urandom_range(1));
      run = $urandom_range(run_max, run_min);
      for (k = 0; k < run && left > 0; k++) begin
        ga = a;
        gb = b;
        if ($urandom_range(99) < 6) ga = ~a;
        if ($urandom_range(99) < 6) gb = ~b;
        e = ($urandom_range(99) < 80) ? '0 : ERR_W'($urandom_range(3));
        send_item(ga, gb, e);
        left--;
      end
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // fill bits above the field width with junk; the block must ignore them
  function automatic logic [CDAT_W-1:0] with_junk(input int v, input int w);
    return CDAT_W'(v) | (CDAT_W'($urandom) << w);
  endfunction

  task automatic apply_config(input int deb, input int dly, input int dtap, input int oa,
                              input int ca, input int ob, input int cb);
    set_register(CFG_DEBOUNCE,   with_junk(deb, DEB_W));
    set_register(CFG_GATE_DELAY, with_junk(dly, DELAY_W));
    set_register(CFG_DOUBLE_TAP, with_junk(dtap, DTAP_W));
    set_register(CFG_OPEN_A,     with_junk(oa, ANGLE_W));
    set_register(CFG_CLOSED_A,   with_junk(ca, ANGLE_W));
    set_register(CFG_OPEN_B,     with_junk(ob, ANGLE_W));
    set_register(CFG_CLOSED_B,   with_junk(cb, ANGLE_W));
    set_register(CFG_SPARE,      CDAT_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    idle_on          = 1'b1;
    want_stall       = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.a_level    = 1'b1;
    in_ch.b_level    = 1'b1;
    in_ch.error_code = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_DEBOUNCE;
    cfg_ch.data      = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    drive_segment(30, 52, 60, 30);

    settle();
    apply_config(0, 0, 10, 180, 0, 180, 45);
    for (int i = 0; i < 25; i++) begin
      code = DIRECTED_TICKS[99 - 4 * i -: 4];
      send_item(code[3], code[2], code[1:0]);
    end

    settle();
    apply_config(0, 0, 0, 0, 180, 0, 180);
    drive_segment(20, 1, 4, 20);

    settle();
    apply_config(1000, 180, 10000, 180, 0, 180, 0);
    drive_segment(10, 1, 40, 20);

    settle();
    apply_config(2, 1, 30, $urandom_range(180), $urandom_range(180),
                 $urandom_range(180), $urandom_range(180));
    want_stall = 1'b1;
    drive_segment(20, 1, 12, 15);
    // fresh one-second countdown, held released until it closes servo B
    repeat (30) send_item(1'b0, 1'b1, '0);
    repeat (5) send_item(1'b1, 1'b1, '0);
    repeat (5) send_item(1'b1, 1'b0, '0);
    repeat (1010) send_item(1'b1, 1'b1, ERR_W'($urandom_range(3)));

    settle();
    idle_on = 1'b0;
    apply_config(3, 255, 0, 255, $urandom_range(255), $urandom_range(255), 255);
    drive_segment(10, 1, 14, 10);

    settle();
    idle_on = 1'b1;
    apply_config(1, 2, 10, $urandom_range(180), $urandom_range(180),
                 $urandom_range(180), $urandom_range(180));
    drive_segment(10, 1, 10, 25);

    settle();
    if (fail_count == 0) begin
      $display("tb_two_switch_gate_interlock_unit: done, clean");
    end else begin
      $display("tb_two_switch_gate_interlock_unit: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/tsgi_pkg.sv
rtl/core/tsgi_ifs.sv
rtl/core/tsgi_cfg_regs.sv
rtl/core/tsgi_ctrl.sv
rtl/core/two_switch_gate_interlock_unit.sv
tb/tsgi_interlock_monitor.sv
tb/tb_two_switch_gate_interlock_unit.sv
